// ----- rtl/cave_automaton_smoothing_pass_top_assert.svh -----
// Assertion macros for the cave smoothing block.
// Each macro samples on clk and is disabled while rst is high.
`ifndef CAVE_AUTOMATON_SMOOTHING_PASS_TOP_ASSERT_SVH
`define CAVE_AUTOMATON_SMOOTHING_PASS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
`define CAS_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);
`else
`define CAS_ASSERT(label, prop, msg)
`define CAS_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ----- rtl/cas_pkg.sv -----
`default_nettype none
package cas_pkg;

  // Sizes of the configuration fields
  localparam int unsigned GRID_WIDTH_W  = 11;
  localparam int unsigned GRID_HEIGHT_W = 13;

  // Register reset values and legal range
  localparam int unsigned WIDTH_RESET   = 64;
  localparam int unsigned HEIGHT_RESET  = 64;
  localparam int unsigned GRID_MIN      = 3;
  localparam int unsigned HEIGHT_MAX    = 4096;

  // Default line store depth
  localparam int unsigned MAX_ROW_CELLS_DEF = 1024;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Neighbour count and the keep threshold
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned KEEP_COUNT = 4;

  // Register index, taken from the word address bit
  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_t;

  // Per-cell flags handed from the address stage to the kernel
  typedef struct packed {
    logic v;           // cell entering the window (wall for padding)
    logic result_en;   // this step yields a result
    logic left_oob;    // centre sits on the first column
    logic right_oob;   // centre sits on the last column
    logic top_oob;     // centre sits on the first row
    logic bottom_oob;  // centre sits on the last row
    logic frame_last;  // centre is the frame's final cell
  } cas_tap_t;

endpackage
`default_nettype wire

// ----- rtl/cas_stream_if.sv -----
`default_nettype none
// Cell word channel
interface cas_cell_if;
  logic valid;
  logic ready;
  logic cell_wall;
  logic flush;

  modport source (output valid, output cell_wall, output flush, input ready);
  modport sink (input valid, input cell_wall, input flush, output ready);
endinterface

// Result word channel
interface cas_result_if;
  logic valid;
  logic ready;
  logic new_wall;
  logic frame_last;

  modport source (output valid, output new_wall, output frame_last, input ready);
  modport sink (input valid, input new_wall, input frame_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/cas_cfg_regs.sv -----
`default_nettype none
module cas_cfg_regs import cas_pkg::*; #(
  parameter int unsigned MAX_ROW_CELLS = MAX_ROW_CELLS_DEF,
  parameter int unsigned WCNT_W        = $clog2(MAX_ROW_CELLS + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_W-1:0]    paddr,
  input  wire logic [APB_DATA_W-1:0]    pwdata,
  output logic      [APB_DATA_W-1:0]    prdata,
  output logic                          pready,
  output logic      [WCNT_W-1:0]        width_eff,
  output logic      [GRID_HEIGHT_W-1:0] height_eff,
  output logic                          restart
);

  logic [GRID_WIDTH_W-1:0]  grid_width;
  logic [GRID_HEIGHT_W-1:0] grid_height;
  logic                     wr_fire;
  reg_idx_t                 wr_idx;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;
  assign wr_idx  = reg_idx_t'(paddr[2]);
  assign restart = wr_fire;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_W'(WIDTH_RESET);
      grid_height <= GRID_HEIGHT_W'(HEIGHT_RESET);
    end else if (wr_fire) begin
      case (wr_idx)
        REG_GRID_WIDTH:  grid_width  <= pwdata[GRID_WIDTH_W-1:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[GRID_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (wr_idx)
      REG_GRID_WIDTH:  prdata = APB_DATA_W'(grid_width);
      REG_GRID_HEIGHT: prdata = APB_DATA_W'(grid_height);
      default:         prdata = '0;
    endcase
  end

  // Clamp width to the line store depth
  always_comb begin
    if (32'(grid_width) < GRID_MIN) begin
      width_eff = WCNT_W'(GRID_MIN);
    end else if (32'(grid_width) > MAX_ROW_CELLS) begin
      width_eff = WCNT_W'(MAX_ROW_CELLS);
    end else begin
      width_eff = WCNT_W'(grid_width);
    end
  end

  // Clamp height to the supported rows
  always_comb begin
    if (32'(grid_height) < GRID_MIN) begin
      height_eff = GRID_HEIGHT_W'(GRID_MIN);
    end else if (32'(grid_height) > HEIGHT_MAX) begin
      height_eff = GRID_HEIGHT_W'(HEIGHT_MAX);
    end else begin
      height_eff = grid_height;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cas_line_mem.sv -----
`default_nettype none
module cas_line_mem import cas_pkg::*; #(
  parameter int unsigned MAX_ROW_CELLS = MAX_ROW_CELLS_DEF,
  parameter int unsigned ADDR_W        = $clog2(MAX_ROW_CELLS)
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [1:0]        rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [1:0]        wr_data
);

  // One entry per column: {two rows back, one row back}
  logic [1:0] mem [MAX_ROW_CELLS];

  // Write the column after its cell leaves the kernel
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read the column as its cell is taken in
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cas_kernel.sv -----
`default_nettype none
module cas_kernel import cas_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       clear,
  input  wire logic       step,
  input  wire cas_tap_t   tap,
  input  wire logic [1:0] line_col,
  output logic            new_wall
);

  logic [8:0]         window;
  logic [8:0]         window_next;
  logic [2:0]         col;
  logic [COUNT_W-1:0] count;

  // Column entering on the right: bit 0 top, bit 2 bottom
  assign col         = {tap.v, line_col[0], line_col[1]};
  assign window_next = {col, window[8:3]};

  // Count walls among the eight neighbours, outside cells as walls
  always_comb begin
    logic oob;
    count = '0;
    for (int k = 0; k < 3; k++) begin
      for (int t = 0; t < 3; t++) begin
        oob = (k == 0 && tap.left_oob) || (k == 2 && tap.right_oob) ||
              (t == 0 && tap.top_oob) || (t == 2 && tap.bottom_oob);
        if (!(k == 1 && t == 1)) begin
          count = count + COUNT_W'(oob || window_next[k*3+t]);
        end
      end
    end
  end

  // Apply the 4-5 rule: keep the centre on a tie
  always_comb begin
    if (count > COUNT_W'(KEEP_COUNT)) begin
      new_wall = 1'b1;
    end else if (count < COUNT_W'(KEEP_COUNT)) begin
      new_wall = 1'b0;
    end else begin
      new_wall = window_next[4];
    end
  end

  // Shift the window; empty it at frame end, on reset or on restart
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      window <= '0;
    end else if (step) begin
      window <= tap.frame_last ? '0 : window_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cave_automaton_smoothing_pass_top.sv -----
// Channel  | Dir | Word fields          | Handshake
// ---------+-----+----------------------+--------------------
// cells    | in  | cell_wall, flush     | valid / ready
// results  | out | new_wall, frame_last | valid / ready
// apb      | in  | grid_width, height   | psel / penable, pready = 1
//
// One cell word per cycle while results is not stalled; a result leaves through
// the kernel stage, where the column line store read returns, and the output register.
// The first grid_width+1 words of a frame give no result.
// Reset clears positions, window and valids; the line store needs no clearing.
// A stall on results holds the output register and the kernel stage; cells
// keeps flowing while the kernel stage is empty.
`default_nettype none
`include "cave_automaton_smoothing_pass_top_assert.svh"
module cave_automaton_smoothing_pass_top import cas_pkg::*; #(
  parameter int unsigned MAX_ROW_CELLS = MAX_ROW_CELLS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  cas_cell_if.sink                   cells,
  cas_result_if.source               results,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned ADDR_W = $clog2(MAX_ROW_CELLS);
  localparam int unsigned WCNT_W = $clog2(MAX_ROW_CELLS + 1);

  logic [WCNT_W-1:0]        width_eff;
  logic [GRID_HEIGHT_W-1:0] height_eff;
  logic [GRID_HEIGHT_W-1:0] h_plus1;
  logic [ADDR_W-1:0]        col_last;
  logic                     restart;

  logic [ADDR_W-1:0]        col_pos;
  logic [ADDR_W-1:0]        col_pos_next;
  logic [GRID_HEIGHT_W-1:0] row_pos;
  logic [GRID_HEIGHT_W-1:0] row_pos_next;

  logic                     in_fire;
  logic                     advance;
  logic                     step;
  logic                     c0;
  cas_tap_t                 tap_next;

  logic                     s1_valid;
  cas_tap_t                 s1_tap;
  logic [ADDR_W-1:0]        s1_col;

  logic [1:0]               line_col;
  logic                     kern_wall;

  logic                     out_valid;
  logic                     out_wall;
  logic                     out_last;

  logic                     last_fire;
  logic                     pos_zero;

  // Registers
  cas_cfg_regs #(
    .MAX_ROW_CELLS (MAX_ROW_CELLS),
    .WCNT_W        (WCNT_W)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .restart    (restart)
  );

  assign col_last = ADDR_W'(width_eff - WCNT_W'(1));
  assign h_plus1  = height_eff + GRID_HEIGHT_W'(1);

  // Handshake
  assign advance     = !out_valid || results.ready;
  assign step        = s1_valid && advance;
  assign cells.ready = !s1_valid || advance;
  assign in_fire     = cells.valid && cells.ready;

  // Classify the centre cell from the incoming position
  assign c0 = (col_pos == '0);
  always_comb begin
    tap_next.v          = cells.flush || (row_pos >= height_eff) || cells.cell_wall;
    tap_next.result_en  = !((row_pos == '0) || (row_pos == GRID_HEIGHT_W'(1) && c0));
    tap_next.left_oob   = (col_pos == ADDR_W'(1));
    tap_next.right_oob  = c0;
    tap_next.top_oob    = c0 ? (row_pos == GRID_HEIGHT_W'(2)) : (row_pos == GRID_HEIGHT_W'(1));
    tap_next.bottom_oob = c0 ? (row_pos == h_plus1) : (row_pos == height_eff);
    tap_next.frame_last = c0 && (row_pos == h_plus1);
  end

  // Advance the raster position; restart after the final cell
  always_comb begin
    if (tap_next.frame_last) begin
      col_pos_next = '0;
      row_pos_next = '0;
    end else if (col_pos == col_last) begin
      col_pos_next = '0;
      row_pos_next = row_pos + GRID_HEIGHT_W'(1);
    end else begin
      col_pos_next = col_pos + ADDR_W'(1);
      row_pos_next = row_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (in_fire) begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
    end
  end

  // Kernel stage: holds the word while the line store read returns
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tap <= tap_next;
      s1_col <= col_pos;
    end
  end

  // Column line store: read on accept, write back when the word leaves
  cas_line_mem #(
    .MAX_ROW_CELLS (MAX_ROW_CELLS),
    .ADDR_W        (ADDR_W)
  ) u_line (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_pos),
    .rd_data (line_col),
    .wr_en   (step),
    .wr_addr (s1_col),
    .wr_data ({line_col[0], s1_tap.v})
  );

  cas_kernel u_kernel (
    .clk      (clk),
    .rst      (rst),
    .clear    (restart),
    .step     (step),
    .tap      (s1_tap),
    .line_col (line_col),
    .new_wall (kern_wall)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && s1_tap.result_en;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_wall <= kern_wall;
      out_last <= s1_tap.frame_last;
    end
  end

  assign results.valid      = out_valid;
  assign results.new_wall   = out_wall;
  assign results.frame_last = out_last;

  // Checks
  assign last_fire = in_fire && tap_next.frame_last && !restart;
  assign pos_zero  = (col_pos == '0) && (row_pos == '0);

  `CAS_ASSERT(a_ready_when_out_empty, !results.valid |-> cells.ready, "ready low, output empty")
  `CAS_ASSERT(a_restart_on_last, last_fire |=> pos_zero, "position not restarted after final cell")
  `CAS_ASSERT_NEVER(a_col_range, col_pos > col_last, "column beyond row width")
  `CAS_ASSERT_NEVER(a_row_range, row_pos > h_plus1, "row beyond flush rows")

endmodule
`default_nettype wire
